// ===== rtl/core/bbfp_pkg.sv =====
// Shared types and constants of the bounding-box fit projector.
package bbfp_pkg;

  // Field and datapath widths fixed by the coordinate and pixel formats.
  localparam int unsigned LAT_W  = 28;
  localparam int unsigned LNG_W  = 29;
  localparam int unsigned DIM_W  = 32;
  localparam int unsigned SCL_W  = 64;
  localparam int unsigned HALF_W = 32;
  // Largest span is a longitude span, which fits the longitude width.
  localparam int unsigned SPAN_W = LNG_W;
  // Offset magnitude from a bound always fits the longitude width.
  localparam int unsigned MAG_W  = LNG_W;
  localparam int unsigned PROD_W = MAG_W + HALF_W;
  localparam int unsigned SUM_W  = MAG_W + SCL_W;
  localparam int unsigned NUM_AXES = 2;
  localparam int unsigned AXIS_X = 0;
  localparam int unsigned AXIS_Y = 1;

  // Request kinds carried in the input tuser.
  localparam logic [1:0] REQ_CLEAR   = 2'd0;
  localparam logic [1:0] REQ_ADD     = 2'd1;
  localparam logic [1:0] REQ_FINAL   = 2'd2;
  localparam logic [1:0] REQ_PROJECT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VIEW_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_VIEW_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_EDGE_PADDING = 2'd2;

  // Configuration reset values in Q16.16 pixels.
  localparam logic [DIM_W-1:0] VIEW_WIDTH_RST   = 32'd78643200;
  localparam logic [DIM_W-1:0] VIEW_HEIGHT_RST  = 32'd52428800;
  localparam logic [DIM_W-1:0] EDGE_PADDING_RST = 32'd3276800;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic add_point;
    logic scale_init;
    logic div_start;
    logic div_axis;
    logic scale_commit;
    logic capture;
    logic mul;
    logic sum;
    logic place;
  } bbfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic span_x_zero;
    logic span_y_zero;
    logic div_done;
  } bbfp_status_t;

endpackage

// ===== rtl/core/bounding_box_fit_projector.sv =====
// Clear and add-bound requests leave the controller idle, so the next may follow straight away.
// A final bound point keeps the input stalled while the bit-serial divider works out
// one quotient for each axis with a nonzero span.
// A projection steps through capture, multiply, sum and place, and place waits while the output is full;
// input is taken again as the result enters the output register, so a new projection waits for the last one.
// Reset loads the default view registers and clears bounds and scale; no clearing pass.
module bounding_box_fit_projector import bbfp_pkg::*; #(
  parameter int unsigned SCALE_FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // latitude [27:0], longitude [56:28], zero fill
  input  logic [1:0]  s_axis_tuser_i,   // req_type [1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // pos_x [31:0], pos_y [63:32]
  output logic [0:0]  m_axis_tuser_o    // scale_ready [0]
);

  bbfp_cmd_t    cmd;
  bbfp_status_t status;
  logic [DIM_W-1:0] pos_x, pos_y;
  logic             scale_ready;

  bbfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bbfp_datapath #(
    .FRAC_BITS (SCALE_FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .lat_i         (s_axis_tdata_i[LAT_W-1:0]),
    .lng_i         (s_axis_tdata_i[LAT_W+LNG_W-1:LAT_W]),
    .cmd_i         (cmd),
    .status_o      (status),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .scale_ready_o (scale_ready)
  );

  assign m_axis_tdata_o = {pos_y, pos_x};
  assign m_axis_tuser_o = scale_ready;

endmodule

// ===== rtl/core/bbfp_div.sv =====
// Bit-serial restoring divider for the fixed-point scale quotient.
module bbfp_div import bbfp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIM_W-1:0]  num_i,
  input  logic [SPAN_W-1:0] span_i,
  output logic              done_o,
  output logic [SCL_W-1:0]  quot_o
);

  localparam int unsigned QW = DIM_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(QW + 1);

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [SPAN_W-1:0] rem_q, rem_d;
  logic [SPAN_W-1:0] span_q;
  logic [QW-1:0]     dq_q;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   trial_sub;
  logic              fits;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial     = {rem_q, dq_q[QW-1]};
    trial_sub = trial - {1'b0, span_q};
    fits      = (trial >= {1'b0, span_q});
    rem_d     = fits ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
  end

  // Control: busy flag, step counter and the done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits fill in at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q   <= {num_i, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      span_q <= span_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[QW-2:0], fits};
      rem_q <= rem_d;
    end
  end

  // A quotient wider than the scale saturates to all ones.
  generate
    if (QW > SCL_W) begin : g_sat
      assign quot_o = (dq_q[QW-1:SCL_W] != '0) ? {SCL_W{1'b1}} : dq_q[SCL_W-1:0];
    end else if (QW == SCL_W) begin : g_exact
      assign quot_o = dq_q;
    end else begin : g_ext
      assign quot_o = {{(SCL_W-QW){1'b0}}, dq_q};
    end
  endgenerate

  assign done_o = done_q;

endmodule

// ===== rtl/core/bbfp_datapath.sv =====
// Datapath: configuration, bounds, scale accumulation and point projection.
module bbfp_datapath import bbfp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [DIM_W-1:0]   cfg_wdata_i,
  input  logic [LAT_W-1:0]   lat_i,
  input  logic [LNG_W-1:0]   lng_i,
  input  bbfp_cmd_t          cmd_i,
  output bbfp_status_t       status_o,
  output logic [DIM_W-1:0]   pos_x_o,
  output logic [DIM_W-1:0]   pos_y_o,
  output logic               scale_ready_o
);

  logic [DIM_W-1:0]  view_width_q, view_height_q, edge_padding_q;
  logic [LNG_W-1:0]  lng_low_q, lng_high_q;
  logic [LAT_W-1:0]  lat_low_q, lat_high_q;
  logic              have_points_q;
  logic [SCL_W-1:0]  scale_q, acc_q;
  logic              scale_valid_q, any_q;

  logic [LNG_W:0]    span_x_full;
  logic [LAT_W:0]    span_y_full;
  logic [SPAN_W-1:0] span_x, span_y;
  logic [DIM_W:0]    twice_pad;
  logic [DIM_W-1:0]  dim_sel;
  logic [DIM_W:0]    dim_diff;
  logic [DIM_W-1:0]  usable;
  logic              div_done;
  logic [SCL_W-1:0]  quot;

  logic [LNG_W:0]    diff [NUM_AXES];
  logic [LNG_W:0]    diff_abs [NUM_AXES];
  logic [MAG_W-1:0]  mag_q [NUM_AXES];
  logic              neg_q [NUM_AXES];
  logic [PROD_W-1:0] plo_q [NUM_AXES];
  logic [PROD_W-1:0] phi_q [NUM_AXES];
  logic [SUM_W-1:0]  total [NUM_AXES];
  logic              ovf [NUM_AXES];
  logic [DIM_W:0]    smag_d [NUM_AXES];
  logic [DIM_W:0]    smag_q [NUM_AXES];
  logic [DIM_W+1:0]  pad_sum [NUM_AXES];
  logic [DIM_W-1:0]  pos_d [NUM_AXES];
  logic [DIM_W-1:0]  pos_q [NUM_AXES];
  logic              ready_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_width_q   <= VIEW_WIDTH_RST;
      view_height_q  <= VIEW_HEIGHT_RST;
      edge_padding_q <= EDGE_PADDING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_VIEW_WIDTH:   view_width_q   <= cfg_wdata_i;
        CFG_VIEW_HEIGHT:  view_height_q  <= cfg_wdata_i;
        CFG_EDGE_PADDING: edge_padding_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Running bounds; the first point after reset or clear sets all four.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lng_low_q     <= '0;
      lng_high_q    <= '0;
      lat_low_q     <= '0;
      lat_high_q    <= '0;
      have_points_q <= 1'b0;
    end else if (cmd_i.clear) begin
      lng_low_q     <= '0;
      lng_high_q    <= '0;
      lat_low_q     <= '0;
      lat_high_q    <= '0;
      have_points_q <= 1'b0;
    end else if (cmd_i.add_point) begin
      have_points_q <= 1'b1;
      if (!have_points_q || ($signed(lng_i) < $signed(lng_low_q)))  lng_low_q  <= lng_i;
      if (!have_points_q || ($signed(lng_i) > $signed(lng_high_q))) lng_high_q <= lng_i;
      if (!have_points_q || ($signed(lat_i) < $signed(lat_low_q)))  lat_low_q  <= lat_i;
      if (!have_points_q || ($signed(lat_i) > $signed(lat_high_q))) lat_high_q <= lat_i;
    end
  end

  // Spans are never negative since the high bound never falls below the low one.
  always_comb begin
    span_x_full = {lng_high_q[LNG_W-1], lng_high_q} - {lng_low_q[LNG_W-1], lng_low_q};
    span_y_full = {lat_high_q[LAT_W-1], lat_high_q} - {lat_low_q[LAT_W-1], lat_low_q};
    span_x      = span_x_full[SPAN_W-1:0];
    span_y      = SPAN_W'(span_y_full[LAT_W-1:0]);
  end

  // Usable size of the selected axis: dimension less twice the padding, floored at zero.
  always_comb begin
    twice_pad = {edge_padding_q, 1'b0};
    dim_sel   = cmd_i.div_axis ? view_height_q : view_width_q;
    dim_diff  = {1'b0, dim_sel} - twice_pad;
    usable    = ({1'b0, dim_sel} > twice_pad) ? dim_diff[DIM_W-1:0] : '0;
  end

  bbfp_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (usable),
    .span_i  (cmd_i.div_axis ? span_y : span_x),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Scale: keep the smaller quotient of the axes used, then commit it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q         <= '0;
      any_q         <= 1'b0;
      scale_q       <= '0;
      scale_valid_q <= 1'b0;
    end else if (cmd_i.clear) begin
      scale_q       <= '0;
      scale_valid_q <= 1'b0;
    end else if (cmd_i.scale_init) begin
      acc_q <= '0;
      any_q <= 1'b0;
    end else if (div_done) begin
      if (!any_q || (quot < acc_q)) acc_q <= quot;
      any_q <= 1'b1;
    end else if (cmd_i.scale_commit) begin
      scale_q       <= acc_q;
      scale_valid_q <= 1'b1;
    end
  end

  // Signed offsets from the bounds: x from the low longitude, y down from the high latitude.
  always_comb begin
    diff[AXIS_X] = {lng_i[LNG_W-1], lng_i} - {lng_low_q[LNG_W-1], lng_low_q};
    diff[AXIS_Y] = (LNG_W+1)'($signed({lat_high_q[LAT_W-1], lat_high_q})
                              - $signed({lat_i[LAT_W-1], lat_i}));
    for (int a = 0; a < NUM_AXES; a++) begin
      diff_abs[a] = diff[a][LNG_W] ? (~diff[a] + 1'b1) : diff[a];
    end
  end

  // Magnitude times scale halves, summed, shifted to pixels, offset by padding and clamped.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      total[a]  = SUM_W'(plo_q[a]) + {phi_q[a], {HALF_W{1'b0}}};
      ovf[a]    = (total[a][SUM_W-1:FRAC_BITS+DIM_W] != '0);
      smag_d[a] = ovf[a] ? {1'b1, {DIM_W{1'b0}}} : {1'b0, total[a][FRAC_BITS+DIM_W-1:FRAC_BITS]};
      pad_sum[a] = {2'b00, edge_padding_q} + {1'b0, smag_q[a]};
      if (!neg_q[a]) begin
        pos_d[a] = (pad_sum[a][DIM_W+1:DIM_W] != 2'b00) ? {DIM_W{1'b1}}
                                                         : pad_sum[a][DIM_W-1:0];
      end else begin
        pos_d[a] = (smag_q[a] > {1'b0, edge_padding_q}) ? '0
                                                          : edge_padding_q - smag_q[a][DIM_W-1:0];
      end
    end
  end

  // Projection pipeline registers, stepped by the controller.
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (cmd_i.capture) begin
        neg_q[a] <= diff[a][LNG_W];
        mag_q[a] <= diff_abs[a][MAG_W-1:0];
      end
      if (cmd_i.mul) begin
        plo_q[a] <= PROD_W'(mag_q[a]) * PROD_W'(scale_q[HALF_W-1:0]);
        phi_q[a] <= PROD_W'(mag_q[a]) * PROD_W'(scale_q[SCL_W-1:HALF_W]);
      end
      if (cmd_i.sum) begin
        smag_q[a] <= smag_d[a];
      end
      if (cmd_i.place) begin
        pos_q[a] <= pos_d[a];
      end
    end
    if (cmd_i.place) begin
      ready_q <= scale_valid_q;
    end
  end

  assign status_o.span_x_zero = (span_x == '0);
  assign status_o.span_y_zero = (span_y == '0);
  assign status_o.div_done    = div_done;
  assign pos_x_o       = pos_q[AXIS_X];
  assign pos_y_o       = pos_q[AXIS_Y];
  assign scale_ready_o = ready_q;

endmodule

// ===== rtl/core/bbfp_ctrl.sv =====
// Controller: request decode, scale sequencing and projection stepping.
module bbfp_ctrl import bbfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   req_type_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  bbfp_status_t status_i,
  output bbfp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV_X  = 4'd1;
  localparam logic [3:0] S_WAIT_X = 4'd2;
  localparam logic [3:0] S_DIV_Y  = 4'd3;
  localparam logic [3:0] S_WAIT_Y = 4'd4;
  localparam logic [3:0] S_COMMIT = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_PLACE  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            REQ_CLEAR: cmd_o.clear = 1'b1;
            REQ_ADD:   cmd_o.add_point = 1'b1;
            REQ_FINAL: begin
              cmd_o.add_point  = 1'b1;
              cmd_o.scale_init = 1'b1;
              state_d          = S_DIV_X;
            end
            REQ_PROJECT: begin
              cmd_o.capture = 1'b1;
              state_d       = S_MUL;
            end
            default: ;
          endcase
        end
      end
      S_DIV_X: begin
        if (status_i.span_x_zero) begin
          state_d = S_DIV_Y;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_WAIT_X;
        end
      end
      S_WAIT_X: begin
        if (status_i.div_done) state_d = S_DIV_Y;
      end
      S_DIV_Y: begin
        cmd_o.div_axis = 1'b1;
        if (status_i.span_y_zero) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_WAIT_Y;
        end
      end
      S_WAIT_Y: begin
        if (status_i.div_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.scale_commit = 1'b1;
        state_d            = S_IDLE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_PLACE;
      end
      S_PLACE: begin
        if (out_free) begin
          cmd_o.place = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The output register holds a result until the downstream side takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.place) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
